@@ rtl/ytpq_pkg.sv @@
// Shared types, constants and cell addressing for the Young tableau queue.
// No dependencies.
`default_nettype none
package ytpq_pkg;
    localparam int SIDE   = 8;
    localparam int CELLS  = SIDE * SIDE;
    localparam int IDX_W  = $clog2(SIDE);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int DIAG_W = IDX_W + 2;
    localparam int KEY_W  = 32;
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef enum logic [1:0] {
        MODE_PUSH = 2'd0,
        MODE_POP  = 2'd1,
        MODE_FIND = 2'd2,
        MODE_NOP  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_UP_RD, S_UP_LF, S_UP_EV, S_POP_RD, S_POP_LAST, S_POP_WR,
        S_DN_RD, S_DN_LO, S_DN_EV, S_FD_RD, S_FD_EV, S_KEY_WR, S_MIN_RD,
        S_MIN_CAP, S_FIN
    } t_state;

    typedef struct packed {
        logic                    re;
        logic                    we;
        logic [ADDR_W-1:0]       addr;
        logic signed [KEY_W-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        t_status                 status;
        logic                    found;
        logic signed [KEY_W-1:0] removed_value;
        logic signed [KEY_W-1:0] min_value;
        logic [CNT_W-1:0]        entry_count;
        logic                    is_empty;
        logic                    is_full;
    } t_result;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        logic [ADDR_W:0] a;
        a = (ADDR_W+1)'(row) * (ADDR_W+1)'(SIDE) + (ADDR_W+1)'(col);
        return a[ADDR_W-1:0];
    endfunction
endpackage
`default_nettype wire

@@ rtl/ytpq_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module ytpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ rtl/ytpq_seq.sv @@
// Sequencer: push, pop and find walks over the cell RAM, fill position and count.
// Depends on ytpq_pkg.
`default_nettype none
module ytpq_seq (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [1:0]                       i_mode,
    input  wire logic signed [ytpq_pkg::KEY_W-1:0] i_key,
    output logic                                  o_idle,
    input  wire logic                             i_slot_free,
    output logic                                  o_done,
    output ytpq_pkg::t_result                     o_res,
    output ytpq_pkg::t_mem_req                    o_mem,
    input  wire logic [ytpq_pkg::KEY_W-1:0]       i_rdata
);
    localparam int IW = ytpq_pkg::IDX_W;
    localparam int DW = ytpq_pkg::DIAG_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(ytpq_pkg::SIDE - 1);
    localparam logic signed [IW:0] LAST_ROW = (IW+1)'(ytpq_pkg::SIDE - 1);

    ytpq_pkg::t_state r_state, n_state;
    logic signed [IW:0] r_lr, n_lr;
    logic [IW-1:0] r_lc, n_lc, r_cr, n_cr, r_cc, n_cc;
    logic signed [IW:0] r_fr, n_fr;
    logic [ytpq_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic signed [ytpq_pkg::KEY_W-1:0] r_key, n_key, r_a, n_a, r_rem, n_rem, r_min, n_min;
    ytpq_pkg::t_status r_st, n_st;
    logic r_found, n_found;
    logic [ytpq_pkg::CELLS-1:0] r_valid;
    logic r_rd_vld;
    logic signed [ytpq_pkg::KEY_W-1:0] q, bv;
    logic signed [DW-1:0] diag;
    logic mv_a, mv_b;

    assign q = r_rd_vld ? $signed(i_rdata) : ytpq_pkg::KEY_MAX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ytpq_pkg::S_IDLE;
            r_lr    <= '1;
            r_lc    <= '0;
            r_cnt   <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_lr    <= n_lr;
            r_lc    <= n_lc;
            r_cnt   <= n_cnt;
            if (o_mem.we) begin
                r_valid[o_mem.addr] <= 1'b1;
            end
        end
        r_rd_vld <= r_valid[o_mem.addr];
        r_cr <= n_cr; r_cc <= n_cc; r_fr <= n_fr;
        r_key <= n_key; r_a <= n_a; r_rem <= n_rem; r_min <= n_min;
        r_st <= n_st; r_found <= n_found;
    end

    always_comb begin
        n_state = r_state; n_lr = r_lr; n_lc = r_lc; n_cnt = r_cnt;
        n_cr = r_cr; n_cc = r_cc; n_fr = r_fr; n_key = r_key; n_a = r_a;
        n_rem = r_rem; n_min = r_min; n_st = r_st; n_found = r_found;
        o_mem = '0; o_done = 1'b0; bv = r_key; mv_a = 1'b0; mv_b = 1'b0;
        diag = '0;
        unique case (r_state)
            ytpq_pkg::S_IDLE: begin
                if (i_start) begin
                    n_st = ytpq_pkg::ST_DONE; n_found = 1'b0; n_rem = '0;
                    n_key = i_key; n_state = ytpq_pkg::S_MIN_RD;
                    unique case (ytpq_pkg::t_mode'(i_mode))
                        ytpq_pkg::MODE_PUSH: begin
                            if (r_cnt == ytpq_pkg::CNT_W'(ytpq_pkg::CELLS)) begin
                                n_st = ytpq_pkg::ST_FULL;
                            end else begin
                                diag = DW'(r_lr) + DW'({1'b0, r_lc}) + DW'(1);
                                if (r_lr == LAST_ROW) begin
                                    n_lr = (IW+1)'(diag - DW'(ytpq_pkg::SIDE) + DW'(1));
                                    n_lc = LAST_IDX;
                                end else if (r_lc == '0) begin
                                    n_lr = '0; n_lc = IW'(diag);
                                end else begin
                                    n_lr = r_lr + 1'b1; n_lc = r_lc - 1'b1;
                                end
                                n_cr = IW'(n_lr); n_cc = n_lc;
                                n_cnt = r_cnt + 1'b1;
                                n_state = ytpq_pkg::S_UP_RD;
                            end
                        end
                        ytpq_pkg::MODE_POP: begin
                            if (r_cnt == '0) begin
                                n_st = ytpq_pkg::ST_EMPTY;
                            end else begin
                                n_cnt = r_cnt - 1'b1;
                                n_state = ytpq_pkg::S_POP_RD;
                            end
                        end
                        ytpq_pkg::MODE_FIND: begin
                            if (r_cnt != '0) begin
                                diag = DW'(r_lr) + DW'({1'b0, r_lc});
                                n_fr = (diag > DW'(ytpq_pkg::SIDE - 1)) ?
                                       (IW+1)'(ytpq_pkg::SIDE - 1) : (IW+1)'(diag);
                                n_cc = '0;
                                n_state = ytpq_pkg::S_FD_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ytpq_pkg::S_UP_RD: begin
                o_mem.re = 1'b1; o_mem.addr = ytpq_pkg::cell_addr(r_cr - 1'b1, r_cc);
                n_state = ytpq_pkg::S_UP_LF;
            end
            ytpq_pkg::S_UP_LF: begin
                n_a = q;
                o_mem.re = 1'b1; o_mem.addr = ytpq_pkg::cell_addr(r_cr, r_cc - 1'b1);
                n_state = ytpq_pkg::S_UP_EV;
            end
            ytpq_pkg::S_UP_EV: begin
                if (r_cr != '0 && r_key < r_a) begin
                    bv = r_a; mv_a = 1'b1;
                end
                if (r_cc != '0 && bv < q) begin
                    mv_b = 1'b1; mv_a = 1'b0;
                end
                if (mv_a || mv_b) begin
                    o_mem.we = 1'b1; o_mem.addr = ytpq_pkg::cell_addr(r_cr, r_cc);
                    o_mem.wdata = mv_b ? q : r_a;
                    if (mv_a) n_cr = r_cr - 1'b1; else n_cc = r_cc - 1'b1;
                    n_state = ytpq_pkg::S_UP_RD;
                end else begin
                    n_state = ytpq_pkg::S_KEY_WR;
                end
            end
            ytpq_pkg::S_POP_RD: begin
                o_mem.re = 1'b1; o_mem.addr = '0;
                n_state = ytpq_pkg::S_POP_LAST;
            end
            ytpq_pkg::S_POP_LAST: begin
                n_rem = q;
                o_mem.re = 1'b1; o_mem.addr = ytpq_pkg::cell_addr(IW'(r_lr), r_lc);
                n_state = ytpq_pkg::S_POP_WR;
            end
            ytpq_pkg::S_POP_WR: begin
                n_key = (r_lr == '0 && r_lc == '0) ? ytpq_pkg::KEY_MAX : q;
                o_mem.we = 1'b1; o_mem.addr = ytpq_pkg::cell_addr(IW'(r_lr), r_lc);
                o_mem.wdata = ytpq_pkg::KEY_MAX;
                diag = DW'(r_lr) + DW'({1'b0, r_lc}) - DW'(1);
                if (r_lr == '0) begin
                    n_lr = (IW+1)'(diag); n_lc = '0;
                end else if (r_lc == LAST_IDX) begin
                    n_lr = LAST_ROW;
                    n_lc = IW'(diag - DW'(ytpq_pkg::SIDE) + DW'(1));
                end else begin
                    n_lr = r_lr - 1'b1; n_lc = r_lc + 1'b1;
                end
                n_cr = '0; n_cc = '0;
                n_state = ytpq_pkg::S_DN_RD;
            end
            ytpq_pkg::S_DN_RD: begin
                o_mem.re = 1'b1; o_mem.addr = ytpq_pkg::cell_addr(r_cr, r_cc + 1'b1);
                n_state = ytpq_pkg::S_DN_LO;
            end
            ytpq_pkg::S_DN_LO: begin
                n_a = q;
                o_mem.re = 1'b1; o_mem.addr = ytpq_pkg::cell_addr(r_cr + 1'b1, r_cc);
                n_state = ytpq_pkg::S_DN_EV;
            end
            ytpq_pkg::S_DN_EV: begin
                if (r_cc != LAST_IDX && r_a < r_key) begin
                    bv = r_a; mv_a = 1'b1;
                end
                if (r_cr != LAST_IDX && q < bv) begin
                    mv_b = 1'b1; mv_a = 1'b0;
                end
                if (mv_a || mv_b) begin
                    o_mem.we = 1'b1; o_mem.addr = ytpq_pkg::cell_addr(r_cr, r_cc);
                    o_mem.wdata = mv_b ? q : r_a;
                    if (mv_a) n_cc = r_cc + 1'b1; else n_cr = r_cr + 1'b1;
                    n_state = ytpq_pkg::S_DN_RD;
                end else begin
                    n_state = ytpq_pkg::S_KEY_WR;
                end
            end
            ytpq_pkg::S_FD_RD: begin
                o_mem.re = 1'b1; o_mem.addr = ytpq_pkg::cell_addr(IW'(r_fr), r_cc);
                n_state = ytpq_pkg::S_FD_EV;
            end
            ytpq_pkg::S_FD_EV: begin
                n_state = ytpq_pkg::S_FD_RD;
                if (r_key < q) begin
                    n_fr = r_fr - 1'b1;
                    if (r_fr == '0) n_state = ytpq_pkg::S_MIN_RD;
                end else if (r_key > q) begin
                    n_cc = r_cc + 1'b1;
                    if (r_cc == LAST_IDX) n_state = ytpq_pkg::S_MIN_RD;
                end else begin
                    n_found = 1'b1; n_state = ytpq_pkg::S_MIN_RD;
                end
            end
            ytpq_pkg::S_KEY_WR: begin
                o_mem.we = 1'b1; o_mem.addr = ytpq_pkg::cell_addr(r_cr, r_cc);
                o_mem.wdata = r_key;
                n_state = ytpq_pkg::S_MIN_RD;
            end
            ytpq_pkg::S_MIN_RD: begin
                o_mem.re = 1'b1; o_mem.addr = '0;
                n_state = ytpq_pkg::S_MIN_CAP;
            end
            ytpq_pkg::S_MIN_CAP: begin
                n_min = q; n_state = ytpq_pkg::S_FIN;
            end
            ytpq_pkg::S_FIN: begin
                if (i_slot_free) begin
                    o_done = 1'b1; n_state = ytpq_pkg::S_IDLE;
                end
            end
            default: n_state = ytpq_pkg::S_IDLE;
        endcase
    end

    assign o_idle = (r_state == ytpq_pkg::S_IDLE);

    always_comb begin
        o_res.status        = r_st;
        o_res.found         = r_found;
        o_res.removed_value = r_rem;
        o_res.min_value     = r_min;
        o_res.entry_count   = r_cnt;
        o_res.is_empty      = (r_cnt == '0);
        o_res.is_full       = (r_cnt == ytpq_pkg::CNT_W'(ytpq_pkg::CELLS));
    end
endmodule
`default_nettype wire

@@ rtl/young_tableau_priority_queue_top.sv @@
// Young tableau min-priority queue: sequencer, cell RAM and result register.
// Depends on ytpq_pkg, ytpq_seq, ytpq_ram.
//
// Input channel (i_valid/o_ready) takes one item: mode and key. Modes are
// push, pop minimum and find. Output channel (o_valid/i_ready) gives one
// result per item: status, found flag, removed minimum, new minimum, count and
// empty/full flags.
// Cells live in a single-port RAM with registered read data; each sift step
// is two neighbor reads and one compare/write, each find step one read and
// one compare. Push sifts up to 2*SIDE steps and find walks up to 2*SIDE
// steps; rejects and unused modes go straight to reading the new minimum.
// One item is in work at a time; o_ready is high while the sequencer is idle,
// also while an earlier result still waits in the output register.
// A stalled receiver holds the result; a finished item waits in its last
// state until the output register is free.
// Reset clears the fill position, count and per-cell valid bits, so every
// cell reads as the largest value at once; no clearing pass is needed.
`default_nettype none
module young_tableau_priority_queue_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [1:0]                       i_mode,
    input  wire logic signed [ytpq_pkg::KEY_W-1:0] i_key,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [1:0]                            o_status,
    output logic                                  o_found,
    output logic signed [ytpq_pkg::KEY_W-1:0]     o_removed_value,
    output logic signed [ytpq_pkg::KEY_W-1:0]     o_min_value,
    output logic [ytpq_pkg::CNT_W-1:0]            o_entry_count,
    output logic                                  o_is_empty,
    output logic                                  o_is_full
);
    logic idle, done, slot_free;
    ytpq_pkg::t_result res, r_res;
    ytpq_pkg::t_mem_req mem;
    logic [ytpq_pkg::KEY_W-1:0] rdata;
    logic r_valid;

    assign slot_free = !r_valid || i_ready;
    assign o_ready   = idle;

    ytpq_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_valid && idle),
        .i_mode(i_mode), .i_key(i_key), .o_idle(idle), .i_slot_free(slot_free),
        .o_done(done), .o_res(res), .o_mem(mem), .i_rdata(rdata)
    );

    ytpq_ram #(.WIDTH(ytpq_pkg::KEY_W), .DEPTH(ytpq_pkg::CELLS)) u_ram (
        .i_clk(i_clk), .i_we(mem.we), .i_addr(mem.addr),
        .i_wdata(mem.wdata), .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (done) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (done) begin
            r_res <= res;
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_res.status;
    assign o_found         = r_res.found;
    assign o_removed_value = r_res.removed_value;
    assign o_min_value     = r_res.min_value;
    assign o_entry_count   = r_res.entry_count;
    assign o_is_empty      = r_res.is_empty;
    assign o_is_full       = r_res.is_full;
endmodule
`default_nettype wire

@@ rtl/ytpq_checker.sv @@
// Port-level checks on the queue's result channel, bound to the top level.
// Depends on ytpq_pkg and young_tableau_priority_queue_top.
`default_nettype none
module ytpq_props (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_valid,
    input wire logic                         i_ready,
    input wire logic [1:0]                   o_status,
    input wire logic                         o_found,
    input wire logic [ytpq_pkg::CNT_W-1:0]   o_entry_count,
    input wire logic                         o_is_empty,
    input wire logic                         o_is_full
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_is_empty == (o_entry_count == '0)) else $error("empty flag");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_is_full == (o_entry_count == ytpq_pkg::CNT_W'(ytpq_pkg::CELLS)))
        else $error("full flag");
    a_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ytpq_pkg::ST_EMPTY |-> o_is_empty && !o_found)
        else $error("pop reject while holding keys");
endmodule

bind young_tableau_priority_queue_top ytpq_props u_ytpq_props (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_status(o_status), .o_found(o_found), .o_entry_count(o_entry_count),
    .o_is_empty(o_is_empty), .o_is_full(o_is_full)
);
`default_nettype wire
